@@ hdl/rcsb_pkg.sv @@
// Shared widths, reset values, codes and status types for the RC steering
// and brake command selector. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rcsb_pkg;

  // Field widths
  localparam int STEER_W    = 11;
  localparam int AGE_W      = 16;
  localparam int ANGLE_W    = 17;
  localparam int BRAKE_W    = 16;
  localparam int SERVO_W    = 12;
  localparam int MODE_W     = 2;
  localparam int DZ_W       = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int WINDOW_DEF = 5;

  // Shared divider: numerator and divisor widths
  localparam int NUM_W = 38;
  localparam int DEN_W = 24;

  // Shared multiplier operand widths (signed) and product width
  localparam int MA_W = 24;
  localparam int MB_W = 18;
  localparam int MP_W = 42;

  // Host map: angle * 125 / 2816 is angle / 0.088 degree
  localparam int HOST_MUL = 125;
  localparam int HOST_DIV = 2816;
  // 2816 is 256 * 11: drop eight bits, then multiply by a rounded-up
  // reciprocal of 11; exact for every magnitude up to 104861 after the shift
  localparam int HOST_PRE_SH = 8;
  localparam int HOST_ODD    = HOST_DIV >> HOST_PRE_SH;
  localparam int HOST_SH     = 20;
  localparam int HOST_RCP    = ((1 << HOST_SH) + HOST_ODD - 1) / HOST_ODD;
  localparam logic signed [BRAKE_W-1:0] HOST_BRAKE_ON = 16'sd128;

  // Register reset values
  localparam logic [11:0] LEFT_LIMIT_RST   = 12'd1516;
  localparam logic [11:0] RIGHT_LIMIT_RST  = 12'd829;
  localparam logic [10:0] RC_LEFT_RST      = 11'd995;
  localparam logic [10:0] RC_RIGHT_RST     = 11'd1750;
  localparam logic [10:0] RC_CENTER_RST    = 11'd1420;
  localparam logic [10:0] THR_CENTER_RST   = 11'd1475;
  localparam logic [9:0]  THR_DZ_RST       = 10'd200;
  localparam logic [15:0] EDGE_TIMEOUT_RST = 16'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_LIMIT   = 3'd0,
    CFG_RIGHT_LIMIT  = 3'd1,
    CFG_RC_LEFT      = 3'd2,
    CFG_RC_RIGHT     = 3'd3,
    CFG_RC_CENTER    = 3'd4,
    CFG_THR_CENTER   = 3'd5,
    CFG_THR_DZ       = 3'd6,
    CFG_EDGE_TIMEOUT = 3'd7
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_BRAKE   = 2'd0,
    MODE_TELE    = 2'd1,
    MODE_AUTO    = 2'd2,
    MODE_TIMEOUT = 2'd3
  } mode_t;

  // Status of a multi-cycle unit back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

@@ hdl/rcsb_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on rcsb_pkg for operand widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module rcsb_divider (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rcsb_pkg::NUM_W-1:0] numer,
  input  wire logic [rcsb_pkg::DEN_W-1:0] denom,
  output logic      [rcsb_pkg::NUM_W-1:0] quot,
  output rcsb_pkg::unit_stat_t            stat
);

  localparam int NUM_W = rcsb_pkg::NUM_W;
  localparam int DEN_W = rcsb_pkg::DEN_W;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = numer;
      den_nxt  = denom;
      cnt_nxt  = CNT_W'(NUM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next numerator bit, subtract when it fits
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quot      = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

@@ hdl/rcsb_history.sv @@
// Ring of the last WINDOW steering widths with a serial summing pass.
// Depends on rcsb_pkg for the width and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module rcsb_history #(
  parameter int WINDOW = rcsb_pkg::WINDOW_DEF,
  parameter int SUM_W  = rcsb_pkg::STEER_W + $clog2(WINDOW + 1)
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         push,
  input  wire logic [rcsb_pkg::STEER_W-1:0] push_data,
  input  wire logic                         sum_start,
  output logic      [SUM_W-1:0]             sum,
  output rcsb_pkg::unit_stat_t              stat
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(WINDOW - 1);

  logic [rcsb_pkg::STEER_W-1:0] hist_r [WINDOW];
  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [SLOT_W-1:0]            idx_r, idx_nxt;
  logic [SUM_W-1:0]             acc_r, acc_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;

  // advance the slot first, then store at it
  assign slot_nxt = push ? ((slot_r == LAST) ? '0 : slot_r + SLOT_W'(1)) : slot_r;

  always_comb begin
    idx_nxt  = idx_r;
    acc_nxt  = acc_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (sum_start) begin
      idx_nxt  = '0;
      acc_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + SUM_W'(hist_r[idx_r]);
      idx_nxt = idx_r + SLOT_W'(1);
      if (idx_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        hist_r[i] <= '0;
      end
      slot_r <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      if (push) begin
        hist_r[slot_nxt] <= push_data;
      end
      slot_r <= slot_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign sum       = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

@@ hdl/rc_steering_brake_command_select.sv @@
// Top level of the RC steering and brake command selector: registers,
// sequencer and shared multiplier. Depends on rcsb_pkg, rcsb_history, rcsb_divider.
`timescale 1ns / 1ps
`default_nettype none

// One control tick in, one command out. After a tick is taken, in_ready stays
// low until its command has been moved into the output register and rises at
// the same clock edge. A timeout tick goes straight to S_FIN and from there into
// the output register. An auto tick passes through the angle multiply, a stage
// for the sum and its magnitude, a reciprocal multiply for the divide by 2816
// and the limit clamp. A brake or teleoperated tick sums the steering ring and
// scales the sum by the reciprocal of WINDOW, forms the squares and the
// quadratic term on the shared multiplier and makes a pass of the shared divider
// for the rounded quadratic map, with setup and saturation around them; it skips
// the multiplies and the divide when the average sits at centre or the divisor
// on its side is zero. The divider, one quotient bit a cycle, is the longest
// step. A finished command waits while the output register is still full. The
// output register holds a command until it is taken, and the next tick is
// accepted meanwhile. Configuration writes are always taken (cfg_ready is tied
// high) and must only be made while no tick is in progress.
module rc_steering_brake_command_select #(
  parameter int WINDOW = rcsb_pkg::WINDOW_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // tick input
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic        [rcsb_pkg::STEER_W-1:0] in_steer_width,
  input  wire logic        [rcsb_pkg::STEER_W-1:0] in_throttle_width,
  input  wire logic        [rcsb_pkg::AGE_W-1:0]   in_steer_edge_age,
  input  wire logic        [rcsb_pkg::AGE_W-1:0]   in_throttle_edge_age,
  input  wire logic signed [rcsb_pkg::ANGLE_W-1:0] in_host_angle,
  input  wire logic signed [rcsb_pkg::BRAKE_W-1:0] in_host_brake,
  // command output
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic             [rcsb_pkg::SERVO_W-1:0] out_servo_goal,
  output logic                                     out_brake_on,
  output logic                                     out_relay_level,
  output logic             [rcsb_pkg::MODE_W-1:0]  out_drive_mode,
  // configuration
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic      [rcsb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic     [rcsb_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SUM_W = rcsb_pkg::STEER_W + $clog2(WINDOW + 1);
  localparam int NUM_W = rcsb_pkg::NUM_W;
  localparam int DEN_W = rcsb_pkg::DEN_W;
  localparam int MA_W  = rcsb_pkg::MA_W;
  localparam int MB_W  = rcsb_pkg::MB_W;
  localparam int MP_W  = rcsb_pkg::MP_W;
  // floor(sum / WINDOW) as (sum * AVG_RCP) >> AVG_SH, exact for any ring sum
  localparam int AVG_SH  = rcsb_pkg::STEER_W + 2 * $clog2(WINDOW);
  localparam int AVG_RCP = ((1 << AVG_SH) + WINDOW - 1) / WINDOW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUM,
    S_AVG,
    S_MUL_DD,
    S_MUL_DSQ,
    S_MUL_TERM,
    S_MUL_CTR,
    S_NUM,
    S_Q_DIV,
    S_Q,
    S_HOST_MUL,
    S_HOST_N,
    S_H_RCP,
    S_H_Q,
    S_FIN
  } state_t;

  // ---------------------------------------------------------------- config
  logic [11:0] left_lim_r, right_lim_r;
  logic [10:0] rc_left_r, rc_right_r, rc_center_r, thr_center_r;
  logic [9:0]  thr_dz_r;
  logic [15:0] edge_to_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_lim_r   <= rcsb_pkg::LEFT_LIMIT_RST;
      right_lim_r  <= rcsb_pkg::RIGHT_LIMIT_RST;
      rc_left_r    <= rcsb_pkg::RC_LEFT_RST;
      rc_right_r   <= rcsb_pkg::RC_RIGHT_RST;
      rc_center_r  <= rcsb_pkg::RC_CENTER_RST;
      thr_center_r <= rcsb_pkg::THR_CENTER_RST;
      thr_dz_r     <= rcsb_pkg::THR_DZ_RST;
      edge_to_r    <= rcsb_pkg::EDGE_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (rcsb_pkg::cfg_idx_t'(cfg_index))
        rcsb_pkg::CFG_LEFT_LIMIT:   left_lim_r   <= cfg_data[11:0];
        rcsb_pkg::CFG_RIGHT_LIMIT:  right_lim_r  <= cfg_data[11:0];
        rcsb_pkg::CFG_RC_LEFT:      rc_left_r    <= cfg_data[10:0];
        rcsb_pkg::CFG_RC_RIGHT:     rc_right_r   <= cfg_data[10:0];
        rcsb_pkg::CFG_RC_CENTER:    rc_center_r  <= cfg_data[10:0];
        rcsb_pkg::CFG_THR_CENTER:   thr_center_r <= cfg_data[10:0];
        rcsb_pkg::CFG_THR_DZ:       thr_dz_r     <= cfg_data[9:0];
        rcsb_pkg::CFG_EDGE_TIMEOUT: edge_to_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- derived values
  logic [12:0]        lim_sum;
  logic [11:0]        center_w;
  logic signed [12:0] range_w;

  assign lim_sum  = {1'b0, left_lim_r} + {1'b0, right_lim_r};
  assign center_w = lim_sum[12:1];
  assign range_w  = $signed({1'b0, left_lim_r}) - $signed({1'b0, right_lim_r});

  // tick decode
  logic               timeout_w, auto_w, tele_w, hbrake_w;
  logic signed [12:0] band_lo_w;
  logic [11:0]        band_hi_w;

  assign timeout_w = (in_steer_edge_age >= edge_to_r) || (in_throttle_edge_age >= edge_to_r);
  assign band_lo_w = $signed({2'b0, thr_center_r}) - $signed({3'b0, thr_dz_r});
  assign auto_w    = $signed({2'b0, in_throttle_width}) < band_lo_w;
  assign band_hi_w = {1'b0, thr_center_r} + {2'b0, thr_dz_r};
  assign tele_w    = band_hi_w < {1'b0, in_throttle_width};
  assign hbrake_w  = in_host_brake > rcsb_pkg::HOST_BRAKE_ON;

  // ------------------------------------------------------------ sub-units
  logic                     accept;
  logic                     sum_start_r, sum_start_nxt;
  logic [SUM_W-1:0]         hist_sum;
  rcsb_pkg::unit_stat_t     hist_stat;
  logic                     div_start_r, div_start_nxt;
  logic [NUM_W-1:0]         div_num_r, div_num_nxt;
  logic [DEN_W-1:0]         div_den_r, div_den_nxt;
  logic [NUM_W-1:0]         div_quot;
  rcsb_pkg::unit_stat_t     div_stat;

  assign accept = in_valid && in_ready;

  rcsb_history #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_history (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (in_steer_width),
    .sum_start (sum_start_r),
    .sum       (hist_sum),
    .stat      (hist_stat)
  );

  rcsb_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start_r),
    .numer (div_num_r),
    .denom (div_den_r),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // ------------------------------------------------------------ sequencer
  state_t                     state_r, state_nxt;
  logic signed [16:0]         angle_r, angle_nxt;
  rcsb_pkg::mode_t            mode_r, mode_nxt;
  logic                       brake_r, brake_nxt;
  logic [11:0]                goal_r, goal_nxt;
  logic signed [11:0]         den_r, den_nxt;
  logic [10:0]                d_r, d_nxt;
  logic                       neg_r, neg_nxt;
  logic [22:0]                dd_r, dd_nxt;
  logic signed [MP_W-1:0]     prod_r, prod_nxt;
  logic signed [MP_W-1:0]     term_r, term_nxt;
  logic                       qneg_r, qneg_nxt;
  logic [16:0]                hmag_r, hmag_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [11:0]                out_goal_r, out_goal_nxt;
  logic                       out_brake_r, out_brake_nxt;
  rcsb_pkg::mode_t            out_mode_r, out_mode_nxt;

  logic signed [MA_W-1:0]     mult_a;
  logic signed [MB_W-1:0]     mult_b;

  // RC map working values
  logic [10:0]                avg_w, d_w;
  logic                       left_w;
  logic signed [11:0]         den_l_w, den_r_w, den_w;
  logic signed [14:0]         edge_v_w;
  logic [14:0]                edge_half_w;
  logic signed [MP_W-1:0]     num_w;
  logic [MP_W-1:0]            num_mag_w;
  // host map working values
  logic [MP_W-1:0]            c2816_w;
  logic signed [MP_W-1:0]     hn_w;
  logic [MP_W-1:0]            hn_mag_w;
  logic [15:0]                hq_mag_w;
  logic signed [16:0]         hq_w;

  assign avg_w    = prod_r[AVG_SH +: rcsb_pkg::STEER_W];
  assign left_w   = avg_w < rc_center_r;
  assign den_l_w  = $signed({1'b0, rc_center_r}) - $signed({1'b0, rc_left_r});
  assign den_r_w  = $signed({1'b0, rc_center_r}) - $signed({1'b0, rc_right_r});
  assign den_w    = left_w ? den_l_w : den_r_w;
  assign d_w      = left_w ? (rc_center_r - avg_w) : (avg_w - rc_center_r);
  // zero divisor: centre plus or minus half the range, rounded half away
  assign edge_v_w = left_w ? ($signed({2'b0, center_w, 1'b0}) + 15'(range_w))
                           : ($signed({2'b0, center_w, 1'b0}) - 15'(range_w));
  assign edge_half_w = (edge_v_w + 15'sd1) >>> 1;

  assign num_w     = prod_r + term_r;
  assign num_mag_w = num_w[MP_W-1] ? MP_W'(-num_w) : MP_W'(num_w);

  assign c2816_w  = (MP_W'(center_w) << 11) + (MP_W'(center_w) << 9) + (MP_W'(center_w) << 8);
  assign hn_w     = $signed(c2816_w) + prod_r;
  assign hn_mag_w = hn_w[MP_W-1] ? MP_W'(-hn_w) : MP_W'(hn_w);
  assign hq_mag_w = prod_r[rcsb_pkg::HOST_SH +: 16];
  assign hq_w     = qneg_r ? -$signed({1'b0, hq_mag_w}) : $signed({1'b0, hq_mag_w});

  // shared multiplier operand select
  always_comb begin
    mult_a = '0;
    mult_b = '0;
    case (state_r)
      S_SUM: begin
        mult_a = MA_W'(hist_sum);
        mult_b = MB_W'(AVG_RCP);
      end
      S_MUL_DD: begin
        mult_a = MA_W'(den_r);
        mult_b = MB_W'(den_r);
      end
      S_MUL_DSQ: begin
        mult_a = MA_W'(d_r);
        mult_b = MB_W'(d_r);
      end
      S_MUL_TERM: begin
        mult_a = MA_W'(prod_r[21:0]);
        mult_b = MB_W'(range_w);
      end
      S_MUL_CTR: begin
        mult_a = MA_W'(dd_r);
        mult_b = MB_W'(center_w);
      end
      S_HOST_MUL: begin
        mult_a = MA_W'(angle_r);
        mult_b = MB_W'(rcsb_pkg::HOST_MUL);
      end
      S_H_RCP: begin
        mult_a = MA_W'(rcsb_pkg::HOST_RCP);
        mult_b = MB_W'(hmag_r);
      end
      default: ;
    endcase
  end

  assign prod_nxt = mult_a * mult_b;

  always_comb begin
    state_nxt     = state_r;
    angle_nxt     = angle_r;
    mode_nxt      = mode_r;
    brake_nxt     = brake_r;
    goal_nxt      = goal_r;
    den_nxt       = den_r;
    d_nxt         = d_r;
    neg_nxt       = neg_r;
    dd_nxt        = dd_r;
    term_nxt      = term_r;
    qneg_nxt      = qneg_r;
    hmag_nxt      = hmag_r;
    div_num_nxt   = div_num_r;
    div_den_nxt   = div_den_r;
    div_start_nxt = 1'b0;
    sum_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_goal_nxt  = out_goal_r;
    out_brake_nxt = out_brake_r;
    out_mode_nxt  = out_mode_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          angle_nxt = in_host_angle;
          if (timeout_w) begin
            goal_nxt  = center_w;
            brake_nxt = 1'b1;
            mode_nxt  = rcsb_pkg::MODE_TIMEOUT;
            state_nxt = S_FIN;
          end else if (auto_w) begin
            brake_nxt = hbrake_w;
            mode_nxt  = rcsb_pkg::MODE_AUTO;
            state_nxt = S_HOST_MUL;
          end else begin
            brake_nxt     = !tele_w;
            mode_nxt      = tele_w ? rcsb_pkg::MODE_TELE : rcsb_pkg::MODE_BRAKE;
            sum_start_nxt = 1'b1;
            state_nxt     = S_SUM;
          end
        end
      end
      S_SUM: begin
        // the multiplier scales the finished sum on the way out
        if (hist_stat.done) begin
          state_nxt = S_AVG;
        end
      end
      S_AVG: begin
        den_nxt = den_w;
        d_nxt   = d_w;
        neg_nxt = den_w[11];
        if (avg_w == rc_center_r) begin
          goal_nxt  = center_w;
          state_nxt = S_FIN;
        end else if (den_w == 12'sd0) begin
          goal_nxt  = edge_v_w[14] ? 12'd0 : edge_half_w[11:0];
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_MUL_DD;
        end
      end
      S_MUL_DD: begin
        state_nxt = S_MUL_DSQ;
      end
      S_MUL_DSQ: begin
        dd_nxt    = {prod_r[21:0], 1'b0};
        state_nxt = S_MUL_TERM;
      end
      S_MUL_TERM: begin
        state_nxt = S_MUL_CTR;
      end
      S_MUL_CTR: begin
        // apply the sign of the divisor to the quadratic term
        term_nxt  = neg_r ? -prod_r : prod_r;
        state_nxt = S_NUM;
      end
      S_NUM: begin
        qneg_nxt      = num_w[MP_W-1];
        div_num_nxt   = NUM_W'({num_mag_w[MP_W-2:0], 1'b0}) + NUM_W'(dd_r);
        div_den_nxt   = DEN_W'({dd_r, 1'b0});
        div_start_nxt = 1'b1;
        state_nxt     = S_Q_DIV;
      end
      S_Q_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_Q;
        end
      end
      S_Q: begin
        if (qneg_r) begin
          goal_nxt = 12'd0;
        end else if (|div_quot[NUM_W-1:12]) begin
          goal_nxt = 12'hFFF;
        end else begin
          goal_nxt = div_quot[11:0];
        end
        state_nxt = S_FIN;
      end
      S_HOST_MUL: begin
        state_nxt = S_HOST_N;
      end
      S_HOST_N: begin
        qneg_nxt  = hn_w[MP_W-1];
        hmag_nxt  = hn_mag_w[rcsb_pkg::HOST_PRE_SH +: 17];
        state_nxt = S_H_RCP;
      end
      S_H_RCP: begin
        state_nxt = S_H_Q;
      end
      S_H_Q: begin
        // left limit is checked first, so crossed limits land on one of them
        if (hq_w > $signed({5'b0, left_lim_r})) begin
          goal_nxt = left_lim_r;
        end else if (hq_w < $signed({5'b0, right_lim_r})) begin
          goal_nxt = right_lim_r;
        end else begin
          goal_nxt = hq_w[11:0];
        end
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_goal_nxt  = goal_r;
          out_brake_nxt = brake_r;
          out_mode_nxt  = mode_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      div_start_r <= 1'b0;
      sum_start_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      div_start_r <= div_start_nxt;
      sum_start_r <= sum_start_nxt;
    end
    angle_r     <= angle_nxt;
    mode_r      <= mode_nxt;
    brake_r     <= brake_nxt;
    goal_r      <= goal_nxt;
    den_r       <= den_nxt;
    d_r         <= d_nxt;
    neg_r       <= neg_nxt;
    dd_r        <= dd_nxt;
    prod_r      <= prod_nxt;
    term_r      <= term_nxt;
    qneg_r      <= qneg_nxt;
    hmag_r      <= hmag_nxt;
    div_num_r   <= div_num_nxt;
    div_den_r   <= div_den_nxt;
    out_goal_r  <= out_goal_nxt;
    out_brake_r <= out_brake_nxt;
    out_mode_r  <= out_mode_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_servo_goal  = out_goal_r;
  assign out_brake_on    = out_brake_r;
  assign out_relay_level = !out_brake_r;
  assign out_drive_mode  = out_mode_r;

`ifndef NO_ASSERTIONS
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == S_Q_DIV))
    else $error("divider finished outside its wait state");

  a_sum_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    hist_stat.done |-> (state_r == S_SUM))
    else $error("history sum finished outside the summing state");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input ready straight after a transfer");

  a_timeout_brakes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_drive_mode == rcsb_pkg::MODE_TIMEOUT) |-> out_brake_on)
    else $error("timeout command without brake");

  a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start_r |-> !div_stat.busy)
    else $error("divider restarted while busy");
`endif

endmodule

`default_nettype wire

@@ verif/tb_rc_steering_brake_command_select.sv @@
// Self-checking testbench for rc_steering_brake_command_select: random ticks through
// valid/ready, register writes between phases, command predictor. Depends on rcsb_pkg.
`timescale 1ns / 1ps

module tb_rc_steering_brake_command_select;
  import rcsb_pkg::*;

  localparam int HIST_DEPTH  = WINDOW_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 500;
  localparam int TAIL_CYCLES = 120;

  typedef struct packed {
    logic        [STEER_W-1:0] steer_width;
    logic        [STEER_W-1:0] throttle_width;
    logic        [AGE_W-1:0]   steer_age;
    logic        [AGE_W-1:0]   throttle_age;
    logic signed [ANGLE_W-1:0] host_angle;
    logic signed [BRAKE_W-1:0] host_brake;
  } tick_t;

  typedef struct {
    logic [SERVO_W-1:0] servo_goal;
    logic               brake_on;
    logic               relay_level;
    mode_t              drive_mode;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic        [STEER_W-1:0] in_steer_width = '0;
  logic        [STEER_W-1:0] in_throttle_width = '0;
  logic        [AGE_W-1:0]   in_steer_edge_age = '0;
  logic        [AGE_W-1:0]   in_throttle_edge_age = '0;
  logic signed [ANGLE_W-1:0] in_host_angle = '0;
  logic signed [BRAKE_W-1:0] in_host_brake = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic        [SERVO_W-1:0] out_servo_goal;
  logic                      out_brake_on;
  logic                      out_relay_level;
  logic        [MODE_W-1:0]  out_drive_mode;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic      [CFG_IDX_W-1:0] cfg_index = '0;
  logic     [CFG_DATA_W-1:0] cfg_data = '0;

  rc_steering_brake_command_select DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_steer_width       (in_steer_width),
    .in_throttle_width    (in_throttle_width),
    .in_steer_edge_age    (in_steer_edge_age),
    .in_throttle_edge_age (in_throttle_edge_age),
    .in_host_angle        (in_host_angle),
    .in_host_brake        (in_host_brake),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_servo_goal       (out_servo_goal),
    .out_brake_on         (out_brake_on),
    .out_relay_level      (out_relay_level),
    .out_drive_mode       (out_drive_mode),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #4 clk = ~clk;

  // Predictor copy of the registers and the steering ring
  logic [11:0] left_lim, right_lim;
  logic [10:0] rc_left, rc_right, rc_center, thr_center;
  logic [9:0]  thr_dz;
  logic [15:0] edge_to;
  logic [10:0] steer_ring [HIST_DEPTH];
  int          ring_slot;

  tick_t tick_q[$];
  cmd_t  cmd_expect_q[$];
  tick_t drv_tick;
  int    ticks_queued = 0;
  int    ticks_taken = 0;
  int    results_seen = 0;
  int    errors = 0;
  int    quiet_cycles = 0;
  int    src_idle_pct = 0;
  int    sink_idle_pct = 0;
  int    hold_requests = 0;
  int    hold_served = 0;
  int    last_steer = 1420;

  task automatic reset_model();
    int i;
    left_lim   = LEFT_LIMIT_RST;
    right_lim  = RIGHT_LIMIT_RST;
    rc_left    = RC_LEFT_RST;
    rc_right   = RC_RIGHT_RST;
    rc_center  = RC_CENTER_RST;
    thr_center = THR_CENTER_RST;
    thr_dz     = THR_DZ_RST;
    edge_to    = EDGE_TIMEOUT_RST;
    for (i = 0; i < HIST_DEPTH; i++) steer_ring[i] = '0;
    ring_slot = 0;
  endtask

  task automatic apply_reg(cfg_idx_t idx, logic [15:0] val);
    case (idx)
      CFG_LEFT_LIMIT:   left_lim = val[11:0];
      CFG_RIGHT_LIMIT:  right_lim = val[11:0];
      CFG_RC_LEFT:      rc_left = val[10:0];
      CFG_RC_RIGHT:     rc_right = val[10:0];
      CFG_RC_CENTER:    rc_center = val[10:0];
      CFG_THR_CENTER:   thr_center = val[10:0];
      CFG_THR_DZ:       thr_dz = val[9:0];
      CFG_EDGE_TIMEOUT: edge_to = val;
      default: ;
    endcase
  endtask

  // n / d rounded half away from zero, d > 0
  function automatic longint round_half_away(longint n, longint d);
    if (n >= 0) return (2 * n + d) / (2 * d);
    return -((-2 * n + d) / (2 * d));
  endfunction

  function automatic longint rc_steer_goal(longint avg, longint ctr, longint rng);
    longint c, den, d, dd, num;
    c = rc_center;
    if (avg == c) return ctr;
    if (avg < c) begin
      den = c - longint'(rc_left);
      d = c - avg;
      if (den == 0) return round_half_away(2 * ctr + rng, 2);
    end else begin
      den = c - longint'(rc_right);
      d = avg - c;
      if (den == 0) return round_half_away(2 * ctr - rng, 2);
    end
    dd = 2 * den * den;
    num = ctr * dd + ((den > 0) ? d * d * rng : -(d * d * rng));
    return round_half_away(num, dd);
  endfunction

  function automatic longint host_steer_goal(longint angle, longint ctr);
    longint q;
    // SV division truncates toward zero, as the angle scaling wants
    q = (ctr * HOST_DIV + angle * HOST_MUL) / HOST_DIV;
    if (q > longint'(left_lim)) return left_lim;
    if (q < longint'(right_lim)) return right_lim;
    return q;
  endfunction

  task automatic predict_command(tick_t t);
    longint ctr, rng, sum, avg, goal, tc, dz;
    bit     lost, is_auto, is_tele, brk;
    cmd_t   c;
    int     i;
    ring_slot = (ring_slot + 1) % HIST_DEPTH;
    steer_ring[ring_slot] = t.steer_width;
    sum = 0;
    for (i = 0; i < HIST_DEPTH; i++) sum += longint'(steer_ring[i]);
    avg = sum / HIST_DEPTH;
    ctr = (longint'(left_lim) + longint'(right_lim)) / 2;
    rng = longint'(left_lim) - longint'(right_lim);
    tc = thr_center;
    dz = thr_dz;
    lost = (t.steer_age >= edge_to) || (t.throttle_age >= edge_to);
    is_auto = longint'(t.throttle_width) < tc - dz;
    is_tele = tc + dz < longint'(t.throttle_width);
    if (lost) begin
      goal = ctr;
      brk = 1'b1;
      c.drive_mode = MODE_TIMEOUT;
    end else if (is_auto) begin
      goal = host_steer_goal(longint'($signed(t.host_angle)), ctr);
      brk = $signed(t.host_brake) > $signed(HOST_BRAKE_ON);
      c.drive_mode = MODE_AUTO;
    end else begin
      goal = rc_steer_goal(avg, ctr, rng);
      brk = !is_tele;
      c.drive_mode = is_tele ? MODE_TELE : MODE_BRAKE;
    end
    if (goal < 0) goal = 0;
    else if (goal > 4095) goal = 4095;
    c.servo_goal = goal[11:0];
    c.brake_on = brk;
    c.relay_level = !brk;
    cmd_expect_q.push_back(c);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 40)
      $display("[%0t] result %0d: %s got %0d expected %0d", $time, results_seen, what, got, want);
  endtask

  task automatic check_command();
    cmd_t e;
    if (cmd_expect_q.size() == 0) begin
      report_mismatch("command with nothing pending, servo_goal", out_servo_goal, 0);
      return;
    end
    e = cmd_expect_q.pop_front();
    if (out_servo_goal !== e.servo_goal) report_mismatch("servo_goal", out_servo_goal, e.servo_goal);
    if (out_brake_on !== e.brake_on) report_mismatch("brake_on", out_brake_on, e.brake_on);
    if (out_relay_level !== e.relay_level)
      report_mismatch("relay_level", out_relay_level, e.relay_level);
    if (out_drive_mode !== e.drive_mode)
      report_mismatch("drive_mode", out_drive_mode, e.drive_mode);
  endtask

  // Mostly no gap, some short ones, a few long
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // Tick driver
  int src_wait = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_command(drv_tick);
        ticks_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold the offered tick
      end else if (src_wait > 0) begin
        src_wait--;
        in_valid <= 1'b0;
      end else if (tick_q.size() > 0) begin
        drv_tick = tick_q.pop_front();
        in_steer_width       <= drv_tick.steer_width;
        in_throttle_width    <= drv_tick.throttle_width;
        in_steer_edge_age    <= drv_tick.steer_age;
        in_throttle_edge_age <= drv_tick.throttle_age;
        in_host_angle        <= drv_tick.host_angle;
        in_host_brake        <= drv_tick.host_brake;
        in_valid             <= 1'b1;
        src_wait = pick_gap(src_idle_pct);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Command monitor and receiver back-pressure
  int sink_wait = 0;
  always @(posedge clk) begin
    int g;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_command();
        results_seen++;
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        sink_wait = LONG_HOLD;
      end
      if (sink_wait > 0) begin
        sink_wait--;
        out_ready <= 1'b0;
      end else begin
        g = pick_gap(sink_idle_pct);
        if (g == 0) begin
          out_ready <= 1'b1;
        end else begin
          sink_wait = g - 1;
          out_ready <= 1'b0;
        end
      end
    end
  end

  // Cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic tick_t mk_tick(int sw, int tw, int sa, int ta, int ang, int brk);
    tick_t t;
    t.steer_width    = STEER_W'(sw);
    t.throttle_width = STEER_W'(tw);
    t.steer_age      = AGE_W'(sa);
    t.throttle_age   = AGE_W'(ta);
    t.host_angle     = ANGLE_W'(ang);
    t.host_brake     = BRAKE_W'(brk);
    return t;
  endfunction

  // Aim the tick at the band edges, the timeout edge and the RC range of the current setting
  function automatic tick_t random_tick();
    int tc, dz, tmo, sw, tw, sa, ta, ang, brk, lo, hi;
    tc = thr_center;
    dz = thr_dz;
    tmo = edge_to;
    case ($urandom_range(0, 9))
      0:       tw = $urandom_range(0, 2000);
      1:       tw = tc - dz + $urandom_range(0, 2) - 1;
      2:       tw = tc + dz + $urandom_range(0, 2) - 1;
      3, 4, 5: tw = $urandom_range(clip(tc - dz, 0, 2000), clip(tc + dz, 0, 2000));
      6, 7:    tw = $urandom_range(clip(tc + dz + 1, 0, 2000), 2000);
      default: tw = $urandom_range(0, clip(tc - dz - 1, 0, 2000));
    endcase
    tw = clip(tw, 0, 2000);
    lo = clip((rc_left < rc_right ? int'(rc_left) : int'(rc_right)) - 60, 0, 2000);
    hi = clip((rc_left < rc_right ? int'(rc_right) : int'(rc_left)) + 60, 0, 2000);
    case ($urandom_range(0, 9))
      0, 1, 2:    sw = last_steer;
      3, 4, 5, 6: sw = $urandom_range(lo, hi);
      7:          sw = clip(int'(rc_center) + $urandom_range(0, 6) - 3, 0, 2000);
      default:    sw = $urandom_range(0, 2000);
    endcase
    last_steer = sw;
    sa = $urandom_range(0, tmo > 0 ? tmo - 1 : 0);
    ta = $urandom_range(0, tmo > 0 ? tmo - 1 : 0);
    case ($urandom_range(0, 19))
      0: sa = clip(tmo + $urandom_range(0, 1) - 1, 0, 65535);
      1: ta = clip(tmo + $urandom_range(0, 1) - 1, 0, 65535);
      2: sa = $urandom_range(0, 65535);
      3: ta = $urandom_range(0, 65535);
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0:          ang = $urandom_range(0, 1) ? 46080 : -46080;
      1, 2, 3, 4: ang = $urandom_range(0, 92160) - 46080;
      default:    ang = $urandom_range(0, 6000) - 3000;
    endcase
    if ($urandom_range(0, 1)) brk = $urandom_range(0, 65535);
    else brk = $urandom_range(100, 160);
    return mk_tick(sw, tw, sa, ta, ang, brk);
  endfunction

  task automatic push_tick(tick_t t);
    tick_q.push_back(t);
    ticks_queued++;
  endtask

  // Wait for every tick to be taken and every command to come back
  task automatic drain(int extra);
    while (ticks_taken != ticks_queued || cmd_expect_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Call just after a rising edge; valid stays high across back-to-back writes
  task automatic write_reg(cfg_idx_t idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, CFG_DATA_W'(val));
  endtask

  task automatic set_config(int l, int r, int rl, int rr, int rc, int tc, int dz, int tmo);
    write_reg(CFG_LEFT_LIMIT, l);
    write_reg(CFG_RIGHT_LIMIT, r);
    write_reg(CFG_RC_LEFT, rl);
    write_reg(CFG_RC_RIGHT, rr);
    write_reg(CFG_RC_CENTER, rc);
    write_reg(CFG_THR_CENTER, tc);
    write_reg(CFG_THR_DZ, dz);
    write_reg(CFG_EDGE_TIMEOUT, tmo);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_config();
    int l, r, rl, rr, rc, tc, dz, tmo;
    l   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(1300, 1800);
    r   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095) : $urandom_range(600, 1000);
    rl  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(900, 1200);
    rr  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1600, 2000);
    rc  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1300, 1550);
    tc  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(1400, 1600);
    dz  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(20, 300);
    tmo = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(30, 500);
    set_config(l, r, rl, rr, rc, tc, dz, tmo);
  endtask

  task automatic random_phase(int n, int src_pct, int sink_pct);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    repeat (n) push_tick(random_tick());
    drain(4);
  endtask

  task automatic run_all();
    int k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setting: band is 1275..1675, timeout at 50
    src_idle_pct = 30;
    sink_idle_pct = 30;
    push_tick(mk_tick(1420, 1475, 0, 0, 0, 0));
    push_tick(mk_tick(0, 1274, 0, 0, 46080, 129));
    push_tick(mk_tick(2000, 1275, 0, 0, -46080, 128));
    push_tick(mk_tick(2000, 1675, 0, 0, 0, -32768));
    push_tick(mk_tick(2000, 1676, 0, 0, 0, 0));
    push_tick(mk_tick(0, 2000, 49, 49, 0, 32767));
    push_tick(mk_tick(0, 2000, 50, 0, 100, 200));
    push_tick(mk_tick(0, 0, 0, 50, -100, 200));
    push_tick(mk_tick(2000, 0, 65535, 65535, -46080, -32768));
    push_tick(mk_tick(995, 0, 0, 0, -46080, 32767));
    push_tick(mk_tick(1750, 1000, 0, 0, 1, 127));
    push_tick(mk_tick(1420, 2000, 0, 0, 0, 0));
    push_tick(mk_tick(2000, 2000, 0, 0, 0, 0));
    push_tick(mk_tick(2000, 2000, 0, 0, 0, 0));
    push_tick(mk_tick(2000, 2000, 0, 0, 0, 0));
    push_tick(mk_tick(0, 2000, 0, 0, 0, 0));
    push_tick(mk_tick(0, 2000, 0, 0, 0, 0));
    push_tick(mk_tick(1000, 100, 10, 20, 46080, -1));
    push_tick(mk_tick(1000, 100, 10, 20, -1, 0));
    push_tick(mk_tick(995, 1500, 0, 0, 0, 0));
    drain(4);

    // Zero divisor on the left side, negative divisor on the right
    set_config(2000, 1000, 1420, 1500, 1420, 1500, 100, 100);
    for (k = 0; k < 6; k++) push_tick(mk_tick(k < 3 ? 0 : 2000, 1500, 0, 0, 0, 0));
    random_phase(70, 0, 0);

    // Crossed servo limits
    set_config(800, 1600, 1000, 1800, 1400, 1500, 100, 200);
    random_phase(150, 40, 10);

    // Lower band edge below zero: auto is never selected
    set_config(1516, 829, 995, 1750, 1420, 100, 500, 50);
    random_phase(100, 10, 40);

    // All registers at zero: every tick times out
    set_config(0, 0, 0, 0, 0, 0, 0, 0);
    random_phase(30, 20, 20);

    // All registers at their maximum
    set_config(4095, 4095, 2047, 2047, 2047, 2047, 1023, 65535);
    random_phase(60, 20, 20);

    // Steep map that saturates at both ends; receiver holds off while ticks keep coming
    set_config(4095, 0, 1400, 1440, 1420, 1500, 50, 1000);
    hold_requests++;
    random_phase(200, 0, 20);

    // Negative range, zero divisor on the right side
    set_config(0, 4095, 1410, 1420, 1420, 1475, 200, 300);
    random_phase(150, 25, 25);

    for (k = 0; k < 8; k++) begin
      random_config();
      random_phase(140, (k % 3 == 0) ? 0 : 35, (k % 4 == 1) ? 0 : 35);
    end
    drain(TAIL_CYCLES);
  endtask

  initial begin
    reset_model();
    fork
      run_all();
      wait (quiet_cycles >= STALL_LIMIT);
    join_any
    if (quiet_cycles >= STALL_LIMIT)
      $display("no transfer for %0d cycles, %0d commands outstanding",
               STALL_LIMIT, cmd_expect_q.size());
    if (quiet_cycles < STALL_LIMIT && errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
